### hdl/tsat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsat_pkg
// Shared types and constants of the task switch accounting table.
// ----------------------------------------------------------------------------
package tsat_pkg;

   // field widths
   localparam int TASK_ID_W = 10;
   localparam int PRIO_W    = 8;
   localparam int TIME_W    = 64;
   localparam int COUNT_W   = 64;
   localparam int NICE_W    = 8;
   localparam int TICKET_W  = 11;
   localparam int BASE_W    = 10;
   localparam int STEP_W    = 6;
   localparam int FLOOR_W   = 10;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_TICKET_BASE  = 2'd0;
   localparam logic [1:0] REG_TICKET_STEP  = 2'd1;
   localparam logic [1:0] REG_TICKET_FLOOR = 2'd2;

   // reset values
   localparam logic [BASE_W-1:0]  TICKET_BASE_RST  = 10'd100;
   localparam logic [STEP_W-1:0]  TICKET_STEP_RST  = 6'd10;
   localparam logic [FLOOR_W-1:0] TICKET_FLOOR_RST = 10'd10;

   // scheduling constants
   localparam logic [8:0]        PRIO_NICE_ZERO = 9'd120;
   localparam logic signed [5:0] NICE_MIN       = -6'sd20;
   localparam logic signed [5:0] NICE_MAX       = 6'sd19;
   localparam logic signed [12:0] TICKETS_MAX   = 13'sd2047;

   typedef struct packed {
      logic [BASE_W-1:0]  ticket_base;
      logic [STEP_W-1:0]  ticket_step;
      logic [FLOOR_W-1:0] ticket_floor;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

endpackage
`default_nettype wire

### hdl/tsat_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsat_req_if
// Context switch word channel.
// ----------------------------------------------------------------------------
interface tsat_req_if;
   logic                             valid;
   logic                             ready;
   logic [tsat_pkg::TASK_ID_W-1:0]   outgoing_task;
   logic [tsat_pkg::TASK_ID_W-1:0]   incoming_task;
   logic [tsat_pkg::PRIO_W-1:0]      incoming_priority;
   logic [tsat_pkg::TIME_W-1:0]      time_ns;

   modport source (
      output valid, outgoing_task, incoming_task, incoming_priority, time_ns,
      input  ready
   );
   modport sink (
      input  valid, outgoing_task, incoming_task, incoming_priority, time_ns,
      output ready
   );
endinterface
`default_nettype wire

### hdl/tsat_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsat_rsp_if
// Accounting result word channel.
// ----------------------------------------------------------------------------
interface tsat_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tsat_pkg::TIME_W-1:0]       outgoing_cpu_ns;
   logic [tsat_pkg::COUNT_W-1:0]      outgoing_switch_count;
   logic signed [tsat_pkg::NICE_W-1:0] incoming_nice;
   logic [tsat_pkg::TICKET_W-1:0]     incoming_tickets;

   modport source (
      output valid, outgoing_cpu_ns, outgoing_switch_count, incoming_nice,
             incoming_tickets,
      input  ready
   );
   modport sink (
      input  valid, outgoing_cpu_ns, outgoing_switch_count, incoming_nice,
             incoming_tickets,
      output ready
   );
endinterface
`default_nettype wire

### hdl/tsat_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsat_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### hdl/tsat_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsat_csr
// Ticket configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module tsat_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [tsat_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tsat_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [tsat_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready,
   output tsat_pkg::cfg_type                    cfg
);
   import tsat_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TICKET_BASE:  cfg_in.ticket_base  = pwdata[BASE_W-1:0];
            REG_TICKET_STEP:  cfg_in.ticket_step  = pwdata[STEP_W-1:0];
            REG_TICKET_FLOOR: cfg_in.ticket_floor = pwdata[FLOOR_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticket_base  <= TICKET_BASE_RST;
         cfg_ff.ticket_step  <= TICKET_STEP_RST;
         cfg_ff.ticket_floor <= TICKET_FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TICKET_BASE:  prdata = CSR_DATA_W'(cfg_ff.ticket_base);
         REG_TICKET_STEP:  prdata = CSR_DATA_W'(cfg_ff.ticket_step);
         REG_TICKET_FLOOR: prdata = CSR_DATA_W'(cfg_ff.ticket_floor);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

### hdl/task_switch_accounting_table_unit.sv
`default_nettype none
// A switch word's entries are read on accept and written back in the update state,
//   which waits while the result register holds an unaccepted word; the result word
//   is registered with the write-back, and no new switch word is taken before it.
// Reset: config registers return to base 100, step 10, floor 10; a clearing pass then
//   zeroes TASK_SLOTS RAM entries, one a cycle, before the first word is taken.
// ----------------------------------------------------------------------------
// task_switch_accounting_table_unit
// Per-task runtime, switch count and switch-in time table updated on every
// context switch, with nice and lottery ticket computation for the new task.
// ----------------------------------------------------------------------------
module task_switch_accounting_table_unit #(
   parameter int TASK_SLOTS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tsat_req_if.sink                             req,
   tsat_rsp_if.source                           rsp,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tsat_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tsat_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [tsat_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import tsat_pkg::*;

   localparam int AW     = $clog2(TASK_SLOTS);
   localparam int ACCT_W = TIME_W + COUNT_W;

   cfg_type cfg;

   // control state
   state_type   state_ff, state_in;
   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // latched switch word
   logic               out_hit_ff, in_hit_ff;
   logic [AW-1:0]      out_addr_ff, in_addr_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [PRIO_W-1:0]  prio_ff;

   // result word
   logic [TIME_W-1:0]        rsp_runtime_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic signed [NICE_W-1:0] rsp_nice_ff;
   logic [TICKET_W-1:0]      rsp_tickets_ff;

   // RAM ports
   logic              acct_we, time_we;
   logic [AW-1:0]     acct_waddr, time_waddr, raddr;
   logic [ACCT_W-1:0] acct_wdata, acct_rdata;
   logic [TIME_W-1:0] time_wdata, time_rdata;

   logic req_fire, req_out_hit, req_in_hit, load_rsp;

   // write-back values
   logic [TIME_W-1:0]  old_runtime, new_runtime, elapsed, sin;
   logic [COUNT_W-1:0] new_count;
   logic               add_elapsed;

   // ticket path
   logic signed [8:0]  nice_full;
   logic signed [5:0]  nice_clamp, neg_nice;
   logic signed [12:0] tick_prod, tick_sum, tick_floor;
   logic [TICKET_W-1:0] tickets;

   tsat_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // {runtime, switch count} per task
   tsat_ram #(.WIDTH(ACCT_W), .DEPTH(TASK_SLOTS)) u_acct_ram (
      .clock (clock),
      .we    (acct_we),
      .waddr (acct_waddr),
      .wdata (acct_wdata),
      .raddr (raddr),
      .rdata (acct_rdata)
   );

   // switch-in time per task
   tsat_ram #(.WIDTH(TIME_W), .DEPTH(TASK_SLOTS)) u_time_ram (
      .clock (clock),
      .we    (time_we),
      .waddr (time_waddr),
      .wdata (time_wdata),
      .raddr (raddr),
      .rdata (time_rdata)
   );

   // Accept only in idle: the next word's read must follow the previous write-back.
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   // Ids of zero or beyond the table do nothing.
   assign req_out_hit = (req.outgoing_task != '0) &&
                        (32'(req.outgoing_task) < TASK_SLOTS);
   assign req_in_hit  = (req.incoming_task != '0) &&
                        (32'(req.incoming_task) < TASK_SLOTS);

   // Read the outgoing entry on accept; hold the address while the write-back waits.
   assign raddr = (state_ff == ST_IDLE) ? AW'(req.outgoing_task) : out_addr_ff;

   // Result register must be free (or draining) to complete the update.
   assign load_rsp = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp.ready);

   // Runtime and count update; outgoing reads the old switch-in time even when
   // the same task comes straight back in.
   assign sin         = time_rdata;
   assign old_runtime = acct_rdata[ACCT_W-1:COUNT_W];
   assign elapsed     = now_ff - sin;
   assign add_elapsed = (sin != '0) && (now_ff > sin);
   assign new_runtime = old_runtime + (add_elapsed ? elapsed : '0);
   assign new_count   = acct_rdata[COUNT_W-1:0] + COUNT_W'(1);

   // Nice and tickets from the latched priority.
   always_comb begin
      nice_full = $signed({1'b0, prio_ff}) - $signed(PRIO_NICE_ZERO);
      if (nice_full < NICE_MIN) begin
         nice_clamp = NICE_MIN;
      end else if (nice_full > NICE_MAX) begin
         nice_clamp = NICE_MAX;
      end else begin
         nice_clamp = nice_full[5:0];
      end
      neg_nice   = 6'sd0 - nice_clamp;
      tick_prod  = $signed({7'b0, cfg.ticket_step}) * 13'(neg_nice);
      tick_sum   = $signed({3'b0, cfg.ticket_base}) + tick_prod;
      tick_floor = $signed({3'b0, cfg.ticket_floor});
      if (tick_sum < tick_floor) begin
         tick_sum = tick_floor;
      end
      if (tick_sum > TICKETS_MAX) begin
         tick_sum = TICKETS_MAX;
      end
      tickets = tick_sum[TICKET_W-1:0];
   end

   // Next state and RAM writes.
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      acct_we      = 1'b0;
      time_we      = 1'b0;
      acct_waddr   = out_addr_ff;
      time_waddr   = in_addr_ff;
      acct_wdata   = {new_runtime, new_count};
      time_wdata   = now_ff;
      case (state_ff)
         ST_CLEAR: begin
            // zero one entry of both tables a cycle
            acct_we      = 1'b1;
            time_we      = 1'b1;
            acct_waddr   = clear_cnt_ff;
            time_waddr   = clear_cnt_ff;
            acct_wdata   = '0;
            time_wdata   = '0;
            clear_cnt_in = clear_cnt_ff + AW'(1);
            if (clear_cnt_ff == AW'(TASK_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (load_rsp) begin
               acct_we  = out_hit_ff;
               time_we  = in_hit_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: latch the word on accept, the result on write-back
   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_hit_ff  <= req_out_hit;
         in_hit_ff   <= req_in_hit;
         out_addr_ff <= AW'(req.outgoing_task);
         in_addr_ff  <= AW'(req.incoming_task);
         now_ff      <= req.time_ns;
         prio_ff     <= req.incoming_priority;
      end
      if (load_rsp) begin
         rsp_runtime_ff <= out_hit_ff ? new_runtime : '0;
         rsp_count_ff   <= out_hit_ff ? new_count : '0;
         rsp_nice_ff    <= in_hit_ff ? nice_full[NICE_W-1:0] : '0;
         rsp_tickets_ff <= in_hit_ff ? tickets : '0;
      end
   end

   assign rsp.valid                 = rsp_valid_ff;
   assign rsp.outgoing_cpu_ns       = rsp_runtime_ff;
   assign rsp.outgoing_switch_count = rsp_count_ff;
   assign rsp.incoming_nice         = rsp_nice_ff;
   assign rsp.incoming_tickets      = rsp_tickets_ff;

`ifndef SYNTHESIS
   // an accepted word always moves on to its write-back
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_UPDATE)
      else $error("accepted word did not enter update");

   // no word is taken while the tables are being cleared
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req.ready)
      else $error("word accepted during clearing pass");

   // table writes outside clearing come only with a result load
   assert property (@(posedge clock) disable iff (reset)
      (acct_we || time_we) && state_ff != ST_CLEAR |-> load_rsp)
      else $error("table write without result load");

   // a result appears only after an update completes
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result raised outside update");

   // an unaccepted result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !load_rsp)
      else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Context switch words go into the task switch accounting table. A shadow copy
// of every task entry and of the ticket policy predicts each result word, unless a
// result typed in by hand overrides it; every result word is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
   import tsat_pkg::*;

   localparam int SLOTS           = 1024;
   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PHASES   = 6;
   localparam int WORDS_PER_PHASE = 225;
   localparam int IDLE_PCT        = 16;

   // one context switch, as carried by the request channel
   typedef struct packed {
      logic [TASK_ID_W-1:0] outgoing_task;
      logic [TASK_ID_W-1:0] incoming_task;
      logic [PRIO_W-1:0]    incoming_priority;
      logic [TIME_W-1:0]    time_ns;
   } switch_word_type;

   // one accounting result, as carried by the result channel
   typedef struct packed {
      logic [TIME_W-1:0]   cpu_ns;
      logic [COUNT_W-1:0]  switch_count;
      logic [NICE_W-1:0]   nice;
      logic [TICKET_W-1:0] tickets;
   } account_word_type;

   // a result typed in by hand overrides the shadow's prediction
   typedef struct packed {
      logic             pinned;
      account_word_type word;
   } pinned_note_type;

   typedef enum logic { ROW_POLICY, ROW_SWITCH } row_kind_type;

   typedef struct {
      row_kind_type    kind;
      cfg_type         policy;
      switch_word_type sw;
      pinned_note_type note;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tsat_req_if req_if ();
   tsat_rsp_if rsp_if ();

   task_switch_accounting_table_unit #(
      .TASK_SLOTS (SLOTS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the accounting table and of the ticket policy
   logic [TIME_W-1:0]   runtime_tbl   [SLOTS];
   logic [COUNT_W-1:0]  tally_tbl     [SLOTS];
   logic [TIME_W-1:0]   switch_in_tbl [SLOTS];
   logic [NICE_W-1:0]   nice_tbl      [SLOTS];
   logic [TICKET_W-1:0] ticket_tbl    [SLOTS];
   cfg_type             policy_now;

   account_word_type pending_results [$];
   pinned_note_type  pinned_notes [$];
   int               words_sent   = 0;
   int               results_seen = 0;
   int               mismatches   = 0;
   int               idle_pct     = IDLE_PCT;

   always #HALF_PERIOD clock = ~clock;

   // Walk one switch through the shadow table: outgoing side first, so that a
   // task switching to itself reports the state after its own switch-out.
   function automatic account_word_type account_switch(input switch_word_type w);
      account_word_type acc;
      int               out_id;
      int               in_id;
      int               nice;
      int               clamped;
      int               tix;
      acc    = '0;
      out_id = int'(w.outgoing_task);
      in_id  = int'(w.incoming_task);
      if (out_id != 0 && out_id < SLOTS) begin
         // runtime only grows when the switch-in time is known and in the past
         if (switch_in_tbl[out_id] != '0 && w.time_ns > switch_in_tbl[out_id])
            runtime_tbl[out_id] += w.time_ns - switch_in_tbl[out_id];
         tally_tbl[out_id] += 1;
         acc.cpu_ns       = runtime_tbl[out_id];
         acc.switch_count = tally_tbl[out_id];
      end
      if (in_id != 0 && in_id < SLOTS) begin
         nice    = int'(w.incoming_priority) - int'(PRIO_NICE_ZERO);
         clamped = (nice < int'(NICE_MIN)) ? int'(NICE_MIN) :
                   (nice > int'(NICE_MAX)) ? int'(NICE_MAX) : nice;
         tix     = int'(policy_now.ticket_base) + int'(policy_now.ticket_step) * (-clamped);
         if (tix < int'(policy_now.ticket_floor))
            tix = int'(policy_now.ticket_floor);
         if (tix > int'(TICKETS_MAX))
            tix = int'(TICKETS_MAX);
         switch_in_tbl[in_id] = w.time_ns;
         nice_tbl[in_id]      = nice[NICE_W-1:0];   // stored unclamped, wraps to 8 bits
         ticket_tbl[in_id]    = tix[TICKET_W-1:0];
         acc.nice    = nice_tbl[in_id];
         acc.tickets = ticket_tbl[in_id];
      end
      return acc;
   endfunction

   function automatic stim_row_type sw_row(input int out_id, input int in_id, input int prio,
                                           input logic [63:0] stamp, input bit pinned = 1'b0,
                                           input logic [63:0] run = '0,
                                           input logic [63:0] tally = '0,
                                           input int nice = 0, input int tix = 0);
      stim_row_type row;
      row.kind                 = ROW_SWITCH;
      row.policy               = '0;
      row.sw.outgoing_task     = TASK_ID_W'(out_id);
      row.sw.incoming_task     = TASK_ID_W'(in_id);
      row.sw.incoming_priority = PRIO_W'(prio);
      row.sw.time_ns           = stamp;
      row.note.pinned          = pinned;
      row.note.word.cpu_ns       = run;
      row.note.word.switch_count = tally;
      row.note.word.nice         = NICE_W'(nice);
      row.note.word.tickets      = TICKET_W'(tix);
      return row;
   endfunction

   function automatic stim_row_type policy_row(input int base, input int step, input int min_tix);
      stim_row_type row;
      row.kind                = ROW_POLICY;
      row.policy.ticket_base  = BASE_W'(base);
      row.policy.ticket_step  = STEP_W'(step);
      row.policy.ticket_floor = FLOOR_W'(min_tix);
      row.sw                  = '0;
      row.note                = '0;
      return row;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   // Drop valid and hold until every accepted word has had its result back.
   // Always wait for a clock edge first so that valid never sees two updates
   // in one time step.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (results_seen < words_sent);
   endtask

   // Offer one switch word, idling at random first, and hold it until taken.
   task automatic send_switch(input switch_word_type w, input pinned_note_type note);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      pinned_notes.push_back(note);
      req_if.valid             <= 1'b1;
      req_if.outgoing_task     <= w.outgoing_task;
      req_if.incoming_task     <= w.incoming_task;
      req_if.incoming_priority <= w.incoming_priority;
      req_if.time_ns           <= w.time_ns;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   // Setup then access; psel stays high across back-to-back writes.
   task automatic write_register(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TICKET_BASE:  policy_now.ticket_base  = value[BASE_W-1:0];
         REG_TICKET_STEP:  policy_now.ticket_step  = value[STEP_W-1:0];
         REG_TICKET_FLOOR: policy_now.ticket_floor = value[FLOOR_W-1:0];
         default: ;
      endcase
   endtask

   // Change the ticket policy only once the table has gone quiet.
   task automatic set_ticket_policy(input cfg_type p);
      settle();
      write_register(REG_TICKET_BASE,  CSR_DATA_W'(p.ticket_base));
      write_register(REG_TICKET_STEP,  CSR_DATA_W'(p.ticket_step));
      write_register(REG_TICKET_FLOOR, CSR_DATA_W'(p.ticket_floor));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Result side back-pressure, stalling at the same rate the sender idles.
   always @(posedge clock)
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);

   // Scoreboard: predict on every accepted switch word, then compare the
   // oldest expectation with every accepted result word. Prediction comes
   // first so that a same-edge result would still find its expectation.
   always @(posedge clock) begin : score
      switch_word_type  seen;
      account_word_type want;
      pinned_note_type  note;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen.outgoing_task     = req_if.outgoing_task;
            seen.incoming_task     = req_if.incoming_task;
            seen.incoming_priority = req_if.incoming_priority;
            seen.time_ns           = req_if.time_ns;
            want = account_switch(seen);
            note = pinned_notes.pop_front();
            pending_results.push_back(note.pinned ? note.word : want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result word arrived with no switch word waiting for it");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("outgoing_cpu_ns", want.cpu_ns,
                           rsp_if.outgoing_cpu_ns);
               check_field("outgoing_switch_count", want.switch_count,
                           rsp_if.outgoing_switch_count);
               check_field("incoming_nice", {56'b0, want.nice},
                           {56'b0, rsp_if.incoming_nice});
               check_field("incoming_tickets", {53'b0, want.tickets},
                           {53'b0, rsp_if.incoming_tickets});
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type     directed [$];
      cfg_type          plan [RANDOM_PHASES];
      switch_word_type  w;
      int               roll;
      logic [TASK_ID_W-1:0] running;
      logic [TIME_W-1:0]    wall_ns;

      // initialise every input and the shadow before the first edge
      req_if.valid             = 1'b0;
      req_if.outgoing_task     = '0;
      req_if.incoming_task     = '0;
      req_if.incoming_priority = '0;
      req_if.time_ns           = '0;
      rsp_if.ready             = 1'b0;
      csr_psel                 = 1'b0;
      csr_penable              = 1'b0;
      csr_pwrite               = 1'b0;
      csr_paddr                = '0;
      csr_pwdata               = '0;
      for (int s = 0; s < SLOTS; s++) begin
         runtime_tbl[s]   = '0;
         tally_tbl[s]     = '0;
         switch_in_tbl[s] = '0;
         nice_tbl[s]      = '0;
         ticket_tbl[s]    = '0;
      end
      policy_now.ticket_base  = TICKET_BASE_RST;
      policy_now.ticket_step  = TICKET_STEP_RST;
      policy_now.ticket_floor = TICKET_FLOOR_RST;
      running = '0;
      wall_ns = 64'h1000;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset policy first (base 100, step 10, floor 10).
      // task 0 out: outgoing pair is zero; nice zero gives the base
      directed.push_back(sw_row(0, 5, 120, 1000, 1, 0, 0, 0, 100));
      // task 5 ran from 1000 to 3000; nobody comes in
      directed.push_back(sw_row(5, 0, 0, 3000, 1, 2000, 1, 0, 0));
      // lowest priority: nice -120 stored, tickets from nice -20
      directed.push_back(sw_row(0, 7, 0, 4000, 1, 0, 0, -120, 300));
      // highest normal priority: tickets fall to the floor
      directed.push_back(sw_row(0, 8, 139, 4500, 1, 0, 0, 19, 10));
      // priority 255: nice wraps to 8 bits, tickets use nice 19
      directed.push_back(sw_row(0, 9, 255, 5000, 1, 0, 0, -121, 10));
      // same id on both sides, never switched in before
      directed.push_back(sw_row(3, 3, 120, 6000, 1, 0, 1, 0, 100));
      directed.push_back(sw_row(3, 3, 121, 9000, 1, 3000, 2, 1, 90));
      // switch-out earlier than switch-in: runtime holds, count rises
      directed.push_back(sw_row(7, 0, 120, 100, 1, 0, 1, 0, 0));
      // top slot, priority 247 (nice 127)
      directed.push_back(sw_row(1023, 1023, 247, 1, 1, 0, 1, 127, 10));
      directed.push_back(sw_row(1023, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1,
                                64'hFFFF_FFFF_FFFF_FFFE, 2, 0, 0));
      directed.push_back(sw_row(0, 1023, 128, 1, 1, 0, 0, 8, 20));
      // runtime wraps through 2^64 back to zero
      directed.push_back(sw_row(1023, 0, 0, 3, 1, 0, 3, 0, 0));
      directed.push_back(sw_row(0, 0, 77, 64'hA5A5_5A5A_C3C3_3C3C, 1, 0, 0, 0, 0));
      // switch-out at exactly the switch-in time
      directed.push_back(sw_row(0, 12, 100, 7777, 1, 0, 0, -20, 300));
      directed.push_back(sw_row(12, 0, 0, 7777, 1, 0, 1, 0, 0));
      // switch-in recorded at time zero counts as unknown
      directed.push_back(sw_row(0, 40, 120, 0, 1, 0, 0, 0, 100));
      directed.push_back(sw_row(40, 0, 120, 500, 1, 0, 1, 0, 0));
      // largest base and step: tickets saturate; smallest floor
      directed.push_back(policy_row(1023, 63, 0));
      directed.push_back(sw_row(0, 20, 100, 50, 1, 0, 0, -20, 2047));
      directed.push_back(sw_row(0, 21, 139, 60, 1, 0, 0, 19, 0));
      // floor above everything
      directed.push_back(policy_row(0, 0, 1023));
      directed.push_back(sw_row(20, 22, 120, 64'hFFFF_FFFF_FFFF_FFFF));
      directed.push_back(sw_row(21, 21, 0, 64'h8000_0000_0000_0000));
      directed.push_back(sw_row(22, 20, 200, 5));
      // base, step and floor near but below the tops of their registers
      directed.push_back(policy_row(1000, 50, 1000));
      directed.push_back(sw_row(0, 30, 100, 10, 1, 0, 0, -20, 2000));
      directed.push_back(sw_row(30, 30, 139, 20));

      foreach (directed[r]) begin
         if (directed[r].kind == ROW_POLICY)
            set_ticket_policy(directed[r].policy);
         else
            send_switch(directed[r].sw, directed[r].note);
      end

      // Random part: a few fixed policies including the extremes, then random ones.
      plan[0] = '{ticket_base: 10'd100,  ticket_step: 6'd10, ticket_floor: 10'd10};
      plan[1] = '{ticket_base: 10'd0,    ticket_step: 6'd0,  ticket_floor: 10'd0};
      plan[2] = '{ticket_base: 10'd1023, ticket_step: 6'd63, ticket_floor: 10'd0};
      plan[3] = '{ticket_base: 10'd0,    ticket_step: 6'd63, ticket_floor: 10'd1023};
      for (int ph = 4; ph < RANDOM_PHASES; ph++) begin
         plan[ph].ticket_base  = BASE_W'($urandom_range(1023));
         plan[ph].ticket_step  = STEP_W'($urandom_range(63));
         plan[ph].ticket_floor = FLOOR_W'($urandom_range(1023));
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_ticket_policy(plan[ph]);
         // one phase runs flat out on both sides
         idle_pct = (ph == 2) ? 0 : IDLE_PCT;
         // push the clock near the top of its range so high time bits toggle
         if (ph == 4)
            wall_ns = 64'hFFFF_FFFF_F000_0000;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
               // well-formed: the running task goes out, a pool task comes in
               w.outgoing_task     = running;
               w.incoming_task     = ($urandom_range(15) == 0) ? TASK_ID_W'($urandom) :
                                                               TASK_ID_W'($urandom_range(1, 15));
               w.incoming_priority = ($urandom_range(7) == 0) ? PRIO_W'($urandom) :
                                                              PRIO_W'($urandom_range(100, 139));
               wall_ns            += 64'($urandom_range(1, 100000));
               w.time_ns           = wall_ns;
               running             = w.incoming_task;
            end else if (roll < 88) begin
               // broken: time runs backwards, or the CPU drops to no task
               w.outgoing_task     = running;
               w.incoming_task     = $urandom_range(1) ? '0 : TASK_ID_W'($urandom_range(1, 15));
               w.incoming_priority = PRIO_W'($urandom);
               w.time_ns           = wall_ns - 64'($urandom_range(0, 5000));
               running             = w.incoming_task;
            end else begin
               // noise: every field at random over its full width
               w.outgoing_task     = TASK_ID_W'($urandom);
               w.incoming_task     = TASK_ID_W'($urandom);
               w.incoming_priority = PRIO_W'($urandom);
               w.time_ns           = {$urandom, $urandom};
            end
            send_switch(w, '0);
            // now and then hold the sender until the table has drained
            if ($urandom_range(149) == 0)
               settle();
         end
      end

      // drain, then let the block show any stray word before the final check
      settle();
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d result words never arrived", pending_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("task_switch_accounting_table_unit test passed");
      else
         $display("task_switch_accounting_table_unit test failed");
      $finish;
   end

   // hard stop, far beyond the slowest correct run including the clearing pass
   initial begin
      #(5_000_000);
      $display("task_switch_accounting_table_unit test failed");
      $finish;
   end

endmodule
